/* rtl/wsfd_pkg.sv */
package wsfd_pkg;

   // Parser phase, one-hot
   typedef enum logic [5:0] {
      PH_HDR0  = 6'b000001,
      PH_HDR1  = 6'b000010,
      PH_EXT16 = 6'b000100,
      PH_EXT64 = 6'b001000,
      PH_KEY   = 6'b010000,
      PH_PAY   = 6'b100000
   } phase_type;

   localparam logic [6:0] LEN_EXT16     = 7'd126;
   localparam logic [6:0] LEN_EXT64     = 7'd127;
   localparam logic [2:0] EXT16_LAST    = 3'd1;
   localparam logic [2:0] EXT64_LAST    = 3'd7;
   localparam logic [2:0] KEY_LAST      = 3'd3;
   localparam int         FIN_BIT       = 7;
   localparam int         MASK_BIT      = 7;

   // One output transfer
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       frame_fin;
      logic [3:0] frame_opcode;
      logic       last_of_frame;
   } result_type;

endpackage

/* rtl/wsfd_parser.sv */
module wsfd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   output logic                is_payload,
   output wsfd_pkg::result_type result
);

   wsfd_pkg::phase_type phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [63:0] remain_ff, remain_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_idx_ff, key_idx_in;

   logic [63:0] remain_shift;
   logic [6:0]  len7;
   logic        len_done;
   logic [7:0]  key_byte;

   assign len7         = data_byte[6:0];
   assign remain_shift = {remain_ff[55:0], data_byte};
   assign is_payload   = (phase_ff == wsfd_pkg::PH_PAY);

   // Phase after the length is known
   function automatic wsfd_pkg::phase_type after_length(input logic masked,
                                                        input logic zero_len);
      if (masked) begin
         return wsfd_pkg::PH_KEY;
      end else if (!zero_len) begin
         return wsfd_pkg::PH_PAY;
      end
      return wsfd_pkg::PH_HDR0;
   endfunction

   always_comb begin
      phase_in   = phase_ff;
      fin_in     = fin_ff;
      opcode_in  = opcode_ff;
      masked_in  = masked_ff;
      remain_in  = remain_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      key_idx_in = key_idx_ff;
      len_done   = 1'b0;
      unique case (phase_ff) inside
         wsfd_pkg::PH_HDR1: begin
            masked_in = data_byte[wsfd_pkg::MASK_BIT];
            count_in  = 3'd0;
            if (len7 == wsfd_pkg::LEN_EXT16) begin
               remain_in = 64'd0;
               phase_in  = wsfd_pkg::PH_EXT16;
            end else if (len7 == wsfd_pkg::LEN_EXT64) begin
               remain_in = 64'd0;
               phase_in  = wsfd_pkg::PH_EXT64;
            end else begin
               remain_in  = {57'd0, len7};
               key_idx_in = 2'd0;
               if (data_byte[wsfd_pkg::MASK_BIT]) begin
                  key_in = 32'd0;
               end
               phase_in = after_length(data_byte[wsfd_pkg::MASK_BIT], len7 == 7'd0);
            end
         end
         wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
            remain_in = remain_shift;
            len_done  = (phase_ff == wsfd_pkg::PH_EXT16 && count_ff >= wsfd_pkg::EXT16_LAST)
                     || (phase_ff == wsfd_pkg::PH_EXT64 && count_ff >= wsfd_pkg::EXT64_LAST);
            if (len_done) begin
               count_in   = 3'd0;
               key_idx_in = 2'd0;
               if (masked_ff) begin
                  key_in = 32'd0;
               end
               phase_in = after_length(masked_ff, remain_shift == 64'd0);
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         wsfd_pkg::PH_KEY: begin
            key_in = {key_ff[23:0], data_byte};
            if (count_ff >= wsfd_pkg::KEY_LAST) begin
               count_in = 3'd0;
               phase_in = (remain_ff != 64'd0) ? wsfd_pkg::PH_PAY : wsfd_pkg::PH_HDR0;
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         wsfd_pkg::PH_PAY: begin
            key_idx_in = key_idx_ff + 2'd1;
            remain_in  = remain_ff - 64'd1;
            if (remain_ff == 64'd1) begin
               phase_in = wsfd_pkg::PH_HDR0;
            end
         end
         default: begin
            fin_in    = data_byte[wsfd_pkg::FIN_BIT];
            opcode_in = data_byte[3:0];
            count_in  = 3'd0;
            phase_in  = wsfd_pkg::PH_HDR1;
         end
      endcase
   end

   // Key byte for this payload position, first key byte first
   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      if (!masked_ff) begin
         key_byte = 8'd0;
      end
   end

   assign result.payload_byte  = data_byte ^ key_byte;
   assign result.frame_fin     = fin_ff;
   assign result.frame_opcode  = opcode_ff;
   assign result.last_of_frame = (remain_ff == 64'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= wsfd_pkg::PH_HDR0;
         fin_ff     <= 1'b0;
         opcode_ff  <= 4'd0;
         masked_ff  <= 1'b0;
         remain_ff  <= 64'd0;
         count_ff   <= 3'd0;
         key_ff     <= 32'd0;
         key_idx_ff <= 2'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         opcode_ff  <= opcode_in;
         masked_ff  <= masked_in;
         remain_ff  <= remain_in;
         count_ff   <= count_in;
         key_ff     <= key_in;
         key_idx_ff <= key_idx_in;
      end
   end

   // Payload phase always has bytes left
   a_pay_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsfd_pkg::PH_PAY |-> remain_ff != 64'd0)
      else $error("payload phase with zero remaining length");

   // Key phase never counts past four bytes
   a_key_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsfd_pkg::PH_KEY |-> count_ff <= wsfd_pkg::KEY_LAST)
      else $error("key byte count out of range");

   // Last payload byte returns to header parsing
   a_last_hdr0: assert property (@(posedge clock) disable iff (reset)
      step && is_payload && result.last_of_frame |=> phase_ff == wsfd_pkg::PH_HDR0)
      else $error("frame end did not return to header0");

endmodule

/* rtl/websocket_frame_deframer_top.sv */
// WebSocket frame deframer, receive side. Raw stream bytes enter on the req_
// channel one per transfer; each payload byte leaves on the rsp_ channel
// unmasked, tagged with its frame's fin bit and opcode, with last_of_frame set
// on the final byte of a frame. Header, extended-length and key bytes, and
// zero-length frames, produce no rsp_ transfer. Frames are parsed back to back
// by their length. Throughput is one byte per clock: an input register feeds a
// single parse step (phase update, 64-bit length count-down, key byte XOR)
// that loads the result register, so a payload byte passes the input register
// and then the result register before rsp_valid rises. Only a stalled result
// register holding a payload byte blocks the next payload byte; header bytes
// pass regardless.
module websocket_frame_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_frame_fin,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_last_of_frame
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   wsfd_pkg::result_type rsp_data_ff;

   logic                 is_payload;
   logic                 emit;
   logic                 advance;
   wsfd_pkg::result_type result;

   wsfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .is_payload (is_payload),
      .result     (result)
   );

   // A held byte moves on unless it needs the result slot and the slot is stuck
   assign emit      = in_valid_ff && is_payload;
   assign advance   = in_valid_ff && (!is_payload || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit && advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
      if (emit && advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = rsp_data_ff.payload_byte;
   assign rsp_frame_fin     = rsp_data_ff.frame_fin;
   assign rsp_frame_opcode  = rsp_data_ff.frame_opcode;
   assign rsp_last_of_frame = rsp_data_ff.last_of_frame;

   // A new result never lands on one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit && advance |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten");

   // A stalled input byte stays put for the parser
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost");

   // Only payload bytes raise a result
   a_emit_only_pay: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(in_valid_ff && is_payload) |=> !rsp_valid_ff)
      else $error("result without payload byte");

endmodule
